@@ rtl/med_pkg.sv @@
// Shared types and constants of the min/max envelope decimator.
`default_nettype none
package med_pkg;

   localparam int PW_BITS    = 13;  // pixel_width register width
   localparam int QUOT_BITS  = 13;  // bucket quotient never exceeds the effective pixel width
   localparam int RIDX_BITS  = 12;  // read index field width
   localparam int CSR_IDX_BITS = 3;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_SPAN   = 2'd1;
   localparam logic [1:0] KIND_BUCKET = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WIN_START  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIN_END    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PIX_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INCL_DIS   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_DIS  = 3'd4;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic decode;
      logic mul;
      logic div_start;
      logic addr_set;
      logic mem_rd;
      logic upd;
      logic read_res;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic take;
      logic is_read;
      logic div_done;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/med_div.sv @@
// Restoring divider, one quotient bit per cycle, for the bucket index.
`default_nettype none
module med_div import med_pkg::*; #(
   parameter int DIVISOR_BITS = 48
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [DIVISOR_BITS+QUOT_BITS-1:0]   dividend,
   input  wire logic [DIVISOR_BITS-1:0]             divisor,
   output logic                                     done,
   output logic [QUOT_BITS-1:0]                     quotient
);
   localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [QUOT_BITS-1:0]    low_ff, low_in;
   logic [QUOT_BITS-1:0]    quo_ff, quo_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIVISOR_BITS:0]   trial;
   logic                    ge;

   always_comb begin
      trial   = {rem_ff, low_ff[QUOT_BITS-1]};
      ge      = trial >= {1'b0, divisor};
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // high part is below the divisor since rel <= span
         rem_in  = dividend[DIVISOR_BITS+QUOT_BITS-1:QUOT_BITS];
         low_in  = dividend[QUOT_BITS-1:0];
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIVISOR_BITS'(trial - {1'b0, divisor}) : trial[DIVISOR_BITS-1:0];
         low_in = {low_ff[QUOT_BITS-2:0], 1'b0};
         quo_in = {quo_ff[QUOT_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/med_dp.sv @@
// Datapath: config registers, span tracking, bucket memories and output word.
`default_nettype none
module med_dp import med_pkg::*; #(
   parameter int MAX_BUCKETS = 4096,
   parameter int TIME_BITS   = 48,
   parameter int VALUE_BITS  = 32,
   parameter int CSR_BITS    = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output stat_type                           stat,
   input  wire logic                          csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [CSR_BITS-1:0]           csr_wdata,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [TIME_BITS-1:0]          req_sample_time,
   input  wire logic signed [VALUE_BITS-1:0]  req_sample_value,
   input  wire logic                          req_value_valid,
   input  wire logic                          req_sample_enabled,
   input  wire logic [RIDX_BITS-1:0]          req_bucket_index,
   output logic [1:0]                         rsp_kind,
   output logic                               rsp_bucket_used,
   output logic                               rsp_starts_segment,
   output logic [TIME_BITS-1:0]               rsp_first_time,
   output logic [TIME_BITS-1:0]               rsp_last_time,
   output logic signed [VALUE_BITS-1:0]       rsp_first_value,
   output logic signed [VALUE_BITS-1:0]       rsp_last_value,
   output logic signed [VALUE_BITS-1:0]       rsp_min_value,
   output logic signed [VALUE_BITS-1:0]       rsp_max_value
);
   localparam int IDX_BITS  = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
   localparam int PROD_BITS = TIME_BITS + QUOT_BITS;
   localparam int DW        = 2 * TIME_BITS + 4 * VALUE_BITS;
   // data word: first_time, last_time, first_value, last_value, min, max
   localparam int O_MAX = 0;
   localparam int O_MIN = VALUE_BITS;
   localparam int O_LV  = 2 * VALUE_BITS;
   localparam int O_FV  = 3 * VALUE_BITS;
   localparam int O_LT  = 4 * VALUE_BITS;
   localparam int O_FT  = 4 * VALUE_BITS + TIME_BITS;

   // config
   logic [TIME_BITS-1:0] wstart_ff, wend_ff;
   logic [PW_BITS-1:0]   pwidth_ff;
   logic                 incl_ff, sdis_ff;
   // span tracking
   logic                 in_span_ff, prev_ff;
   logic [TIME_BITS-1:0] span_start_ff;
   // latched word
   logic [1:0]                    op_ff;
   logic [TIME_BITS-1:0]          t_ff;
   logic signed [VALUE_BITS-1:0]  v_ff;
   logic                          vv_ff, en_ff;
   logic [RIDX_BITS-1:0]          idx_ff;
   logic                          idx_ok_ff;
   // result staging
   logic [1:0]                    res_kind_ff;
   logic                          res_used_ff, res_seg_ff;
   logic [TIME_BITS-1:0]          res_ft_ff, res_lt_ff;
   logic signed [VALUE_BITS-1:0]  res_fv_ff, res_lv_ff, res_min_ff, res_max_ff;
   // arithmetic
   logic [TIME_BITS-1:0]  rel_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [IDX_BITS-1:0]   addr_ff;
   logic [IDX_BITS-1:0]   clr_ff;
   // memories
   logic [1:0]    flag_mem [MAX_BUCKETS];
   logic [DW-1:0] data_mem [MAX_BUCKETS];
   logic [1:0]    flag_rd_ff;
   logic [DW-1:0] data_rd_ff;

   logic                 window_ok, in_win, take;
   logic [PW_BITS-1:0]   pw_eff;
   logic [QUOT_BITS-1:0] quot, bucket;
   logic                 div_done;
   logic [DW-1:0]        upd_word;
   logic signed [VALUE_BITS-1:0] old_min, old_max;

   assign window_ok = wend_ff > wstart_ff;
   assign in_win    = (t_ff >= wstart_ff) && (t_ff <= wend_ff);
   assign take      = (op_ff == OP_SAMPLE) && window_ok && in_win && vv_ff
                      && (incl_ff || en_ff);

   always_comb begin
      if (pwidth_ff == '0)
         pw_eff = PW_BITS'(1);
      else if (32'(pwidth_ff) > 32'(MAX_BUCKETS))
         pw_eff = PW_BITS'(MAX_BUCKETS);
      else
         pw_eff = pwidth_ff;
   end

   med_div #(.DIVISOR_BITS(TIME_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (wend_ff - wstart_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign bucket = (quot > QUOT_BITS'(pw_eff - 1'b1)) ? QUOT_BITS'(pw_eff - 1'b1) : quot;

   assign stat.clear_last = clr_ff == IDX_BITS'(MAX_BUCKETS - 1);
   assign stat.take       = take;
   assign stat.is_read    = op_ff == OP_READ;
   assign stat.div_done   = div_done;

   // config and span state
   always_ff @(posedge clock) begin
      if (reset) begin
         wstart_ff     <= '0;
         wend_ff       <= '0;
         pwidth_ff     <= PW_BITS'(1);
         incl_ff       <= 1'b0;
         sdis_ff       <= 1'b0;
         in_span_ff    <= 1'b0;
         span_start_ff <= '0;
         prev_ff       <= 1'b0;
         clr_ff        <= '0;
      end else begin
         if (cmd.clear_step)
            clr_ff <= clr_ff + 1'b1;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WIN_START: wstart_ff <= csr_wdata[TIME_BITS-1:0];
               CSR_WIN_END:   wend_ff   <= csr_wdata[TIME_BITS-1:0];
               CSR_PIX_WIDTH: pwidth_ff <= csr_wdata[PW_BITS-1:0];
               CSR_INCL_DIS:  incl_ff   <= csr_wdata[0];
               CSR_START_DIS: begin
                  sdis_ff       <= csr_wdata[0];
                  in_span_ff    <= csr_wdata[0];
                  span_start_ff <= wstart_ff;
               end
               default: ;
            endcase
         end
         if (cmd.decode) begin
            if (op_ff == OP_SAMPLE && window_ok) begin
               if (!in_win) begin
                  prev_ff <= 1'b0;
               end else begin
                  if (!en_ff && !in_span_ff) begin
                     in_span_ff    <= 1'b1;
                     span_start_ff <= t_ff;
                  end else if (en_ff && in_span_ff) begin
                     in_span_ff <= 1'b0;
                  end
                  if (!take)
                     prev_ff <= 1'b0;
               end
            end else if (op_ff == OP_FINISH) begin
               in_span_ff    <= sdis_ff;
               span_start_ff <= wstart_ff;
               prev_ff       <= 1'b0;
            end
         end
         if (cmd.upd)
            prev_ff <= 1'b1;
      end
   end

   // word capture, staging, arithmetic and output word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         t_ff      <= req_sample_time;
         v_ff      <= req_sample_value;
         vv_ff     <= req_value_valid;
         en_ff     <= req_sample_enabled;
         idx_ff    <= req_bucket_index;
         idx_ok_ff <= 32'(req_bucket_index) < 32'(MAX_BUCKETS);
      end
      if (cmd.decode) begin
         res_kind_ff <= KIND_NONE;
         res_used_ff <= 1'b0;
         res_seg_ff  <= 1'b0;
         res_ft_ff   <= '0;
         res_lt_ff   <= '0;
         res_fv_ff   <= '0;
         res_lv_ff   <= '0;
         res_min_ff  <= '0;
         res_max_ff  <= '0;
         rel_ff      <= t_ff - wstart_ff;
         addr_ff     <= IDX_BITS'(idx_ff);
         if (op_ff == OP_SAMPLE && window_ok && in_win && en_ff && in_span_ff) begin
            res_kind_ff <= KIND_SPAN;
            res_ft_ff   <= span_start_ff;
            res_lt_ff   <= t_ff;
         end else if (op_ff == OP_FINISH && window_ok && in_span_ff) begin
            res_kind_ff <= KIND_SPAN;
            res_ft_ff   <= span_start_ff;
            res_lt_ff   <= wend_ff;
         end else if (op_ff == OP_READ) begin
            res_kind_ff <= KIND_BUCKET;
         end
      end
      if (cmd.mul)
         prod_ff <= PROD_BITS'(rel_ff) * PROD_BITS'(pw_eff);
      if (cmd.addr_set)
         addr_ff <= IDX_BITS'(bucket);
      if (cmd.read_res && idx_ok_ff && flag_rd_ff[0]) begin
         res_used_ff <= 1'b1;
         res_seg_ff  <= flag_rd_ff[1];
         res_ft_ff   <= data_rd_ff[O_FT +: TIME_BITS];
         res_lt_ff   <= data_rd_ff[O_LT +: TIME_BITS];
         res_fv_ff   <= data_rd_ff[O_FV +: VALUE_BITS];
         res_lv_ff   <= data_rd_ff[O_LV +: VALUE_BITS];
         res_min_ff  <= data_rd_ff[O_MIN +: VALUE_BITS];
         res_max_ff  <= data_rd_ff[O_MAX +: VALUE_BITS];
      end
      if (cmd.out_load) begin
         rsp_kind           <= res_kind_ff;
         rsp_bucket_used    <= res_used_ff;
         rsp_starts_segment <= res_seg_ff;
         rsp_first_time     <= res_ft_ff;
         rsp_last_time      <= res_lt_ff;
         rsp_first_value    <= res_fv_ff;
         rsp_last_value     <= res_lv_ff;
         rsp_min_value      <= res_min_ff;
         rsp_max_value      <= res_max_ff;
      end
   end

   // merge of a new sample into the bucket that was read
   always_comb begin
      old_min = data_rd_ff[O_MIN +: VALUE_BITS];
      old_max = data_rd_ff[O_MAX +: VALUE_BITS];
      if (!flag_rd_ff[0]) begin
         upd_word = {t_ff, t_ff, v_ff, v_ff, v_ff, v_ff};
      end else begin
         upd_word = {data_rd_ff[O_FT +: TIME_BITS], t_ff,
                     data_rd_ff[O_FV +: VALUE_BITS], v_ff,
                     (v_ff < old_min) ? v_ff : old_min,
                     (v_ff > old_max) ? v_ff : old_max};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         flag_rd_ff <= flag_mem[addr_ff];
         data_rd_ff <= data_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.clear_step)
         flag_mem[clr_ff] <= 2'b00;
      else if (cmd.upd)
         flag_mem[addr_ff] <= flag_rd_ff[0] ? flag_rd_ff : {~prev_ff, 1'b1};
      else if (cmd.read_res && idx_ok_ff)
         flag_mem[addr_ff] <= 2'b00;
   end

   always_ff @(posedge clock) begin
      if (cmd.upd)
         data_mem[addr_ff] <= upd_word;
   end

endmodule
`default_nettype wire

@@ rtl/med_ctrl.sv @@
// Controller: decodes each word, then a divide and bucket update or a read.
`default_nettype none
module med_ctrl import med_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_MUL    = 4'd3;
   localparam logic [3:0] S_DSTART = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_RD     = 4'd6;
   localparam logic [3:0] S_UPD    = 4'd7;
   localparam logic [3:0] S_RRES   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last)
               state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.take)
               state_in = S_MUL;
            else if (stat.is_read)
               state_in = S_RD;
            else
               state_in = S_DONE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.addr_set = 1'b1;
               state_in     = S_RD;
            end
         end
         S_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = stat.is_read ? S_RRES : S_UPD;
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_DONE;
         end
         S_RRES: begin
            cmd.read_res = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DECODE)
      else $error("accepted word did not go to decode");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !stat.div_done) |=> state_ff == S_DIV)
      else $error("left divide before quotient was ready");

   a_decode_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECODE |=> (state_ff == S_MUL || state_ff == S_RD
                                || state_ff == S_DONE))
      else $error("bad state after decode");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not shown");

endmodule
`default_nettype wire

@@ rtl/minmax_envelope_decimator.sv @@
// A sample that enters a bucket passes decode, multiply, divide start, the divide
// state, where one quotient bit a cycle makes the divider set the sample rate, then
// bucket read and update; a read word passes decode, bucket read and result capture;
// others pass decode only. One word at a time: the next is accepted the cycle after
// a result is loaded, which a low rsp_ready can stall. Reset: synchronous; then a
// clearing pass zeroes all bucket flags, taking no words (CSR writes are taken).
`default_nettype none
module minmax_envelope_decimator import med_pkg::*; #(
   parameter int MAX_BUCKETS = 4096,
   parameter int TIME_BITS   = 48,
   parameter int VALUE_BITS  = 32,
   parameter int CSR_BITS    = TIME_BITS > PW_BITS ? TIME_BITS : PW_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [CSR_BITS-1:0]           csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [TIME_BITS-1:0]          req_sample_time,
   input  wire logic signed [VALUE_BITS-1:0]  req_sample_value,
   input  wire logic                          req_value_valid,
   input  wire logic                          req_sample_enabled,
   input  wire logic [RIDX_BITS-1:0]          req_bucket_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic                               rsp_bucket_used,
   output logic                               rsp_starts_segment,
   output logic [TIME_BITS-1:0]               rsp_first_time,
   output logic [TIME_BITS-1:0]               rsp_last_time,
   output logic signed [VALUE_BITS-1:0]       rsp_first_value,
   output logic signed [VALUE_BITS-1:0]       rsp_last_value,
   output logic signed [VALUE_BITS-1:0]       rsp_min_value,
   output logic signed [VALUE_BITS-1:0]       rsp_max_value
);
   cmd_type  cmd;
   stat_type stat;

   med_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   med_dp #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .TIME_BITS   (TIME_BITS),
      .VALUE_BITS  (VALUE_BITS),
      .CSR_BITS    (CSR_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_opcode         (req_opcode),
      .req_sample_time    (req_sample_time),
      .req_sample_value   (req_sample_value),
      .req_value_valid    (req_value_valid),
      .req_sample_enabled (req_sample_enabled),
      .req_bucket_index   (req_bucket_index),
      .rsp_kind           (rsp_kind),
      .rsp_bucket_used    (rsp_bucket_used),
      .rsp_starts_segment (rsp_starts_segment),
      .rsp_first_time     (rsp_first_time),
      .rsp_last_time      (rsp_last_time),
      .rsp_first_value    (rsp_first_value),
      .rsp_last_value     (rsp_last_value),
      .rsp_min_value      (rsp_min_value),
      .rsp_max_value      (rsp_max_value)
   );

endmodule
`default_nettype wire

@@ sim/minmax_envelope_decimator_checker.sv @@
// Checker for the envelope decimator: watches both channels, predicts each word and compares.
`timescale 1ns / 1ps
module minmax_envelope_decimator_checker import med_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [47:0]             csr_wdata,
   input  wire logic                    req_valid,
   input  wire logic                    req_ready,
   input  wire logic [1:0]              req_opcode,
   input  wire logic [47:0]             req_sample_time,
   input  wire logic signed [31:0]      req_sample_value,
   input  wire logic                    req_value_valid,
   input  wire logic                    req_sample_enabled,
   input  wire logic [RIDX_BITS-1:0]    req_bucket_index,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic [1:0]              rsp_kind,
   input  wire logic                    rsp_bucket_used,
   input  wire logic                    rsp_starts_segment,
   input  wire logic [47:0]             rsp_first_time,
   input  wire logic [47:0]             rsp_last_time,
   input  wire logic signed [31:0]      rsp_first_value,
   input  wire logic signed [31:0]      rsp_last_value,
   input  wire logic signed [31:0]      rsp_min_value,
   input  wire logic signed [31:0]      rsp_max_value,
   output int                           fail_count,
   output int                           pending
);

   localparam int NBUCKETS = 4096;

   typedef struct packed {
      logic [1:0]         kind;
      logic               used;
      logic               seg;
      logic [47:0]        t_first;
      logic [47:0]        t_last;
      logic signed [31:0] v_first;
      logic signed [31:0] v_last;
      logic signed [31:0] v_min;
      logic signed [31:0] v_max;
   } envelope_word_t;

   envelope_word_t expected_words[$];

   logic [47:0] win_start, win_end;
   logic [12:0] pix_width;
   logic        incl_dis, start_dis;

   logic               used_q[NBUCKETS];
   logic               seg_q[NBUCKETS];
   logic [47:0]        t_first_q[NBUCKETS];
   logic [47:0]        t_last_q[NBUCKETS];
   logic signed [31:0] v_first_q[NBUCKETS];
   logic signed [31:0] v_last_q[NBUCKETS];
   logic signed [31:0] v_min_q[NBUCKETS];
   logic signed [31:0] v_max_q[NBUCKETS];
   logic               in_span, prev_valid;
   logic [47:0]        span_start;

   function automatic envelope_word_t envelope_update(
         logic [1:0] op, logic [47:0] t, logic signed [31:0] v, logic vv,
         logic en, logic [11:0] idx);
      envelope_word_t w;
      logic [63:0] span, pw, b;
      w = '0;
      case (op)
         OP_SAMPLE: begin
            if (win_end > win_start) begin
               if (t < win_start || t > win_end) begin
                  prev_valid = 1'b0;
               end else begin
                  if (!en && !in_span) begin
                     in_span = 1'b1;
                     span_start = t;
                  end else if (en && in_span) begin
                     w.kind = KIND_SPAN;
                     w.t_first = span_start;
                     w.t_last = t;
                     in_span = 1'b0;
                  end
                  if (!vv || !(incl_dis || en)) begin
                     prev_valid = 1'b0;
                  end else begin
                     span = 64'(win_end - win_start);
                     pw = (pix_width == 0) ? 64'd1 : 64'(pix_width);
                     if (pw > NBUCKETS) pw = NBUCKETS;
                     b = (64'(t - win_start) * pw) / span;
                     if (b > pw - 1) b = pw - 1;
                     if (!used_q[b]) begin
                        used_q[b] = 1'b1;
                        seg_q[b] = !prev_valid;
                        t_first_q[b] = t;
                        t_last_q[b] = t;
                        v_first_q[b] = v;
                        v_last_q[b] = v;
                        v_min_q[b] = v;
                        v_max_q[b] = v;
                     end else begin
                        t_last_q[b] = t;
                        v_last_q[b] = v;
                        if (v < v_min_q[b]) v_min_q[b] = v;
                        if (v > v_max_q[b]) v_max_q[b] = v;
                     end
                     prev_valid = 1'b1;
                  end
               end
            end
         end
         OP_FINISH: begin
            if (win_end > win_start && in_span) begin
               w.kind = KIND_SPAN;
               w.t_first = span_start;
               w.t_last = win_end;
            end
            in_span = start_dis;
            span_start = win_start;
            prev_valid = 1'b0;
         end
         OP_READ: begin
            w.kind = KIND_BUCKET;
            if (used_q[idx]) begin
               w.used = 1'b1;
               w.seg = seg_q[idx];
               w.t_first = t_first_q[idx];
               w.t_last = t_last_q[idx];
               w.v_first = v_first_q[idx];
               w.v_last = v_last_q[idx];
               w.v_min = v_min_q[idx];
               w.v_max = v_max_q[idx];
            end
            used_q[idx] = 1'b0;
         end
         default: ;
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      envelope_word_t got, exp_w;
      if (reset) begin
         win_start = '0;
         win_end = '0;
         pix_width = 13'd1;
         incl_dis = 1'b0;
         start_dis = 1'b0;
         for (int i = 0; i < NBUCKETS; i++) used_q[i] = 1'b0;
         in_span = 1'b0;
         prev_valid = 1'b0;
         span_start = '0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WIN_START: win_start = csr_wdata;
               CSR_WIN_END:   win_end = csr_wdata;
               CSR_PIX_WIDTH: pix_width = csr_wdata[12:0];
               CSR_INCL_DIS:  incl_dis = csr_wdata[0];
               CSR_START_DIS: begin
                  start_dis = csr_wdata[0];
                  in_span = csr_wdata[0];
                  span_start = win_start;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_words.push_back(envelope_update(req_opcode, req_sample_time,
               req_sample_value, req_value_valid, req_sample_enabled, req_bucket_index));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_bucket_used, rsp_starts_segment, rsp_first_time,
                    rsp_last_time, rsp_first_value, rsp_last_value, rsp_min_value,
                    rsp_max_value};
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result word kind=%0d", $realtime, rsp_kind);
            end else begin
               exp_w = expected_words.pop_front();
               if (got !== exp_w) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch\n  expected %p\n  actual   %p",
                              $realtime, exp_w, got);
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

@@ sim/minmax_envelope_decimator_tb.sv @@
// Top of the envelope decimator testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module minmax_envelope_decimator_tb;
   import med_pkg::*;

   localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [47:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_opcode = OP_SAMPLE;
   logic [47:0] req_sample_time = '0;
   logic signed [31:0] req_sample_value = '0;
   logic req_value_valid = 1'b0;
   logic req_sample_enabled = 1'b0;
   logic [RIDX_BITS-1:0] req_bucket_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic rsp_bucket_used, rsp_starts_segment;
   logic [47:0] rsp_first_time, rsp_last_time;
   logic signed [31:0] rsp_first_value, rsp_last_value, rsp_min_value, rsp_max_value;

   int fail_count, pending;
   logic calm = 1'b0;
   logic hold_rsp = 1'b0;
   int quiet_cycles = 0;

   logic [47:0] ws, we;
   logic [12:0] pw;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   minmax_envelope_decimator uut (.*);

   minmax_envelope_decimator_checker chk (.*);

   // receiver: random stall bursts, one long hold-off on request, none at the end
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 25);
            repeat (n) @(posedge clock);
            if ($urandom_range(0, 2) != 0) begin
               rsp_ready <= 1'b0;
               n = $urandom_range(1, 10);
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic program_window(logic [47:0] s, logic [47:0] e, logic [12:0] w,
                                 logic incl, logic sdis);
      ws = s; we = e; pw = w;
      csr_we <= 1'b1; csr_index <= CSR_WIN_START; csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_WIN_END; csr_wdata <= e;
      @(posedge clock);
      csr_index <= CSR_PIX_WIDTH; csr_wdata <= 48'(w);
      @(posedge clock);
      csr_index <= CSR_INCL_DIS; csr_wdata <= 48'(incl);
      @(posedge clock);
      csr_index <= CSR_START_DIS; csr_wdata <= 48'(sdis);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic send_word(logic [1:0] op, logic [47:0] t, logic signed [31:0] v,
                            logic vv, logic en, logic [11:0] idx);
      int n;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 10);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_sample_time <= t;
      req_sample_value <= v;
      req_value_valid <= vv;
      req_sample_enabled <= en;
      req_bucket_index <= idx;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sample(logic [47:0] t, logic signed [31:0] v, logic vv, logic en);
      send_word(OP_SAMPLE, t, v, vv, en, 12'($urandom));
   endtask

   task automatic read_bucket(logic [11:0] idx);
      send_word(OP_READ, rand48(), $urandom, 1'($urandom), 1'($urandom), idx);
   endtask

   task automatic finish_query();
      send_word(OP_FINISH, rand48(), $urandom, 1'($urandom), 1'($urandom), 12'($urandom));
   endtask

   function automatic logic [47:0] pick_time();
      logic [63:0] span;
      span = 64'(we - ws) + 1;
      if (we <= ws) return rand48();
      case ($urandom_range(0, 9))
         0: return (ws != 0) ? ws - 1 : rand48();
         1: return (we != TMAX) ? we + 1 : rand48();
         2: return rand48();
         3: return ws;
         4: return we;
         default: return ws + 48'(({$urandom, $urandom}) % span);
      endcase
   endfunction

   task automatic random_phase(int items);
      int r;
      logic [47:0] s, e;
      logic [12:0] w;
      case ($urandom_range(0, 5))
         0: begin s = '0; e = TMAX; end
         1: begin s = rand48(); e = (s >> $urandom_range(0, 3)); end
         2: begin s = rand48() >> 1; e = s + $urandom_range(1, 50); end
         3: begin s = rand48() >> 1; e = s + $urandom_range(1000, 100000); end
         4: begin s = TMAX - $urandom_range(1, 5000); e = TMAX; end
         default: begin
            s = rand48(); e = rand48();
            if (s > e) begin s = s ^ e; e = s ^ e; s = s ^ e; end
         end
      endcase
      case ($urandom_range(0, 4))
         0: w = 13'd1;
         1: w = 13'd4096;
         2: w = 13'($urandom_range(1, 4096));
         default: w = 13'($urandom_range(2, 16));
      endcase
      program_window(s, e, w, 1'($urandom), 1'($urandom));
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 68)
            sample(pick_time(), rand_value(), $urandom_range(0, 7) != 0,
                   $urandom_range(0, 4) != 0);
         else if (r < 88)
            read_bucket(12'($urandom_range(0, (pw > 1 ? pw : 1) - 1)));
         else if (r < 93)
            read_bucket(12'($urandom));
         else if (r < 98)
            finish_query();
         else
            send_word(2'd3, rand48(), $urandom, 1'($urandom), 1'($urandom), 12'($urandom));
      end
      finish_query();
      for (int i = 0; i < 16 && i < pw; i++) read_bucket(12'(i));
      req_valid <= 1'b0;
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: span open at window start, extremes of value and time
      program_window(48'd1000, 48'd2000, 13'd4, 1'b0, 1'b1);
      sample(48'd1000, 32'sh7FFF_FFFF, 1'b1, 1'b1);
      sample(48'd1100, 32'sh8000_0000, 1'b1, 1'b1);
      sample(48'd1200, 32'sd0, 1'b1, 1'b0);
      sample(48'd1300, -32'sd1, 1'b0, 1'b0);
      sample(48'd1400, 32'sd5, 1'b0, 1'b1);
      sample(48'd1600, 32'sd7, 1'b1, 1'b1);
      sample(48'd999, 32'sd9, 1'b1, 1'b1);
      sample(48'd2000, 32'sd11, 1'b1, 1'b1);
      sample(48'd2001, 32'sd13, 1'b1, 1'b0);
      sample(TMAX, 32'sd1, 1'b1, 1'b1);
      send_word(2'd3, 48'd1500, 32'sd1, 1'b1, 1'b1, 12'd0);
      sample(48'd1800, 32'sd3, 1'b1, 1'b0);
      finish_query();
      for (int i = 0; i < 4; i++) read_bucket(12'(i));
      read_bucket(12'd4095);
      read_bucket(12'd0);
      req_valid <= 1'b0;
      drain();

      // disabled samples let in; empty window
      program_window(48'd0, TMAX, 13'd4096, 1'b1, 1'b0);
      sample(48'd0, 32'sd2, 1'b1, 1'b0);
      sample(TMAX, 32'sd4, 1'b1, 1'b1);
      finish_query();
      read_bucket(12'd0);
      read_bucket(12'd4095);
      req_valid <= 1'b0;
      drain();
      program_window(48'd500, 48'd500, 13'd1, 1'b0, 1'b1);
      sample(48'd500, 32'sd1, 1'b1, 1'b1);
      finish_query();
      req_valid <= 1'b0;
      drain();

      for (int p = 0; p < 10; p++) begin
         if (p == 3) hold_rsp = 1'b1;
         if (p >= 8) calm = 1'b1;
         random_phase(40);
      end

      req_valid <= 1'b0;
      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/med_pkg.sv
rtl/med_div.sv
rtl/med_dp.sv
rtl/med_ctrl.sv
rtl/minmax_envelope_decimator.sv
sim/minmax_envelope_decimator_checker.sv
sim/minmax_envelope_decimator_tb.sv
